[rtl/tac_pkg.sv]
// Shared types and constants for the accumulator machine execute block.
// Depends on nothing; imported by the execute top level, both checkers and the testbench top.
`default_nettype none

package tac_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int L_SHIFT   = 4;

  typedef enum logic [2:0] {
    CMD_MOV = 3'd0,
    CMD_LDI = 3'd1,
    CMD_JEZ = 3'd2,
    CMD_JNZ = 3'd3,
    CMD_JNI = 3'd4,
    CMD_HLT = 3'd5,
    CMD_RST = 3'd6
  } cmd_t;

  typedef logic [3:0] name_t;

  localparam name_t NAME_A = 4'd0;
  localparam name_t NAME_B = 4'd1;
  localparam name_t NAME_C = 4'd2;
  localparam name_t NAME_D = 4'd3;
  localparam name_t NAME_G = 4'd4;
  localparam name_t NAME_J = 4'd5;
  localparam name_t NAME_L = 4'd6;
  localparam name_t NAME_M = 4'd7;
  localparam name_t NAME_N = 4'd8;
  localparam name_t NAME_P = 4'd9;
  localparam name_t NAME_S = 4'd10;
  localparam name_t NAME_X = 4'd11;
  localparam name_t NAME_Y = 4'd12;
  localparam name_t NAME_Z = 4'd13;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_REG  = 2'd1;
  localparam kind_t KIND_MEM  = 2'd2;

endpackage

`default_nettype wire

[rtl/tiny_accumulator_cpu_execute.sv]
// Execute block of the 8-bit accumulator machine: register file, data memory,
// program counter and halt flag. Uses tac_pkg.
//
// One decoded instruction is taken per clock while results drain. A beat is
// registered in the execute slot, where the synchronous data memory delivers
// mem[A] for that instruction, and its result is then held in the output
// register; the sustained rate is one beat per cycle. The memory read for an
// incoming beat is issued with the A value left by the instruction executing
// in the same cycle, and a memory write in that cycle to the same address is
// forwarded.
// The data memory is not cleared; reading an address through M before it has
// been written returns an undefined byte.
`default_nettype none

module tiny_accumulator_cpu_execute
  import tac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] command,
  input  wire logic [3:0] dest_reg,
  input  wire logic [3:0] src_reg,
  input  wire logic [7:0] immediate,
  input  wire logic [7:0] port_b,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      next_pc,
  output logic            halted_flag,
  output logic [1:0]      write_kind,
  output logic [7:0]      write_target,
  output logic [7:0]      write_value
);

  // Architectural state.
  logic [7:0] reg_a, reg_c, reg_g, reg_x, reg_y;
  logic [7:0] pc;
  logic       halted;
  logic [7:0] data_memory [MEM_DEPTH];

  // Execute slot.
  logic       e_valid;
  cmd_t       e_cmd;
  name_t      e_dst, e_src;
  logic [7:0] e_imm, e_port;
  logic [7:0] mem_rdata;
  logic       fwd_hit;
  logic [7:0] fwd_data;

  logic e_fire, in_accept;

  // Execute results.
  logic [7:0] reg_a_next, reg_c_next, reg_g_next, reg_x_next, reg_y_next;
  logic [7:0] pc_next;
  logic       halted_next;
  kind_t      ex_kind;
  logic [7:0] ex_target, ex_value;
  logic [7:0] src_value, m_value;
  logic       c_zero, dst_writable, mem_we;
  logic [MEM_AW-1:0] rd_addr, wr_addr;

  assign e_fire    = e_valid && (!out_valid || !out_stall);
  assign in_stall  = e_valid && !e_fire;
  assign in_accept = in_valid && !in_stall;

  assign m_value = fwd_hit ? fwd_data : mem_rdata;
  assign c_zero  = (reg_c == 8'd0);

  always_comb begin
    case (e_src)
      NAME_A:  src_value = reg_a;
      NAME_B:  src_value = e_port;
      NAME_C:  src_value = reg_c;
      NAME_D:  src_value = reg_x - reg_y;
      NAME_G:  src_value = reg_g;
      NAME_J:  src_value = {7'd0, !c_zero};
      NAME_L:  src_value = reg_a << L_SHIFT;
      NAME_M:  src_value = m_value;
      NAME_P:  src_value = pc;
      NAME_S:  src_value = reg_x + reg_y;
      NAME_X:  src_value = reg_x;
      NAME_Y:  src_value = reg_y;
      default: src_value = 8'd0;
    endcase
  end

  assign dst_writable = (e_dst == NAME_A) || (e_dst == NAME_C) || (e_dst == NAME_G) ||
                        (e_dst == NAME_X) || (e_dst == NAME_Y);

  always_comb begin
    logic       advance;
    logic [7:0] wval;
    advance     = !halted;
    wval        = 8'd0;
    reg_a_next  = reg_a;
    reg_c_next  = reg_c;
    reg_g_next  = reg_g;
    reg_x_next  = reg_x;
    reg_y_next  = reg_y;
    pc_next     = pc;
    halted_next = halted;
    ex_kind     = KIND_NONE;
    ex_target   = 8'd0;
    ex_value    = 8'd0;
    if (!halted) begin
      unique case (e_cmd)
        CMD_MOV: begin
          if (e_dst == NAME_M) begin
            ex_kind   = KIND_MEM;
            ex_target = reg_a;
            ex_value  = src_value;
          end else if (dst_writable) begin
            ex_kind   = KIND_REG;
            ex_target = {4'd0, e_dst};
            ex_value  = src_value;
            wval      = src_value;
          end
        end
        CMD_LDI: begin
          if (dst_writable) begin
            ex_kind   = KIND_REG;
            ex_target = {4'd0, e_dst};
            ex_value  = e_imm;
            wval      = e_imm;
          end
        end
        CMD_JEZ: begin
          if (c_zero) begin
            pc_next = src_value;
            advance = 1'b0;
          end
        end
        CMD_JNZ: begin
          if (!c_zero) begin
            pc_next = src_value;
            advance = 1'b0;
          end
        end
        CMD_JNI: begin
          if (!c_zero) begin
            pc_next = e_imm;
            advance = 1'b0;
          end
        end
        CMD_HLT: begin
          halted_next = 1'b1;
          advance     = 1'b0;
        end
        CMD_RST: begin
          reg_a_next = 8'd0;
          reg_c_next = 8'd0;
          reg_g_next = 8'd0;
          reg_x_next = 8'd0;
          reg_y_next = 8'd0;
        end
        default: begin
        end
      endcase
      if (ex_kind == KIND_REG) begin
        case (e_dst)
          NAME_A:  reg_a_next = wval;
          NAME_C:  reg_c_next = wval;
          NAME_G:  reg_g_next = wval;
          NAME_X:  reg_x_next = wval;
          NAME_Y:  reg_y_next = wval;
          default: begin
          end
        endcase
      end
      if (advance) begin
        pc_next = pc + 8'd1;
      end
    end
  end

  // The incoming beat must see A as left by the instruction retiring now.
  assign rd_addr = e_fire ? reg_a_next[MEM_AW-1:0] : reg_a[MEM_AW-1:0];
  assign wr_addr = reg_a[MEM_AW-1:0];
  assign mem_we  = e_fire && (ex_kind == KIND_MEM);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_memory[wr_addr] <= ex_value;
    end
    if (in_accept) begin
      mem_rdata <= data_memory[rd_addr];
      fwd_data  <= ex_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_accept) begin
      fwd_hit <= mem_we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (in_accept) begin
      e_valid <= 1'b1;
    end else if (e_fire) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      e_cmd  <= cmd_t'(command);
      e_dst  <= dest_reg;
      e_src  <= src_reg;
      e_imm  <= immediate;
      e_port <= port_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a  <= 8'd0;
      reg_c  <= 8'd0;
      reg_g  <= 8'd0;
      reg_x  <= 8'd0;
      reg_y  <= 8'd0;
      pc     <= 8'd0;
      halted <= 1'b0;
    end else if (e_fire) begin
      reg_a  <= reg_a_next;
      reg_c  <= reg_c_next;
      reg_g  <= reg_g_next;
      reg_x  <= reg_x_next;
      reg_y  <= reg_y_next;
      pc     <= pc_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      next_pc      <= pc_next;
      halted_flag  <= halted_next;
      write_kind   <= ex_kind;
      write_target <= ex_target;
      write_value  <= ex_value;
    end
  end

endmodule

`default_nettype wire

[rtl/tac_checker.sv]
// Port-level checks for the accumulator machine execute block.
// Uses tac_pkg; bound to tiny_accumulator_cpu_execute at the end of this file.
`default_nettype none

module tac_checker
  import tac_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] next_pc,
  input wire logic       halted_flag,
  input wire logic [1:0] write_kind,
  input wire logic [7:0] write_target,
  input wire logic [7:0] write_value
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(write_kind)
      && $stable(write_value) && $stable(write_target) && $stable(halted_flag))
    else $error("stalled result beat changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> write_kind == KIND_NONE || write_kind == KIND_REG
      || write_kind == KIND_MEM)
    else $error("illegal write kind");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_kind == KIND_NONE |-> write_target == 8'd0 && write_value == 8'd0)
    else $error("payload not zero on a beat without a write");

  a_reg_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_kind == KIND_REG |->
      write_target == {4'd0, NAME_A} || write_target == {4'd0, NAME_C}
      || write_target == {4'd0, NAME_G} || write_target == {4'd0, NAME_X}
      || write_target == {4'd0, NAME_Y})
    else $error("register write to a name that is not stored");

  // Once halted, the machine stays halted and writes nothing.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && halted_flag |=> !out_valid
      || (halted_flag && write_kind == KIND_NONE && $stable(next_pc)))
    else $error("halted machine changed state");

endmodule

bind tiny_accumulator_cpu_execute tac_checker u_tac_checker (.*);

`default_nettype wire

[bench/tac_exec_checker.sv]
// Result checker for the accumulator machine execute block. It watches both
// channels, predicts every result beat and compares it with the block.
// Depends on tac_pkg for names, commands and write kinds.
`timescale 1ns / 100ps

module tac_exec_checker
  import tac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] command,
  input  logic [3:0] dest_reg,
  input  logic [3:0] src_reg,
  input  logic [7:0] immediate,
  input  logic [7:0] port_b,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] next_pc,
  input  logic       halted_flag,
  input  logic [1:0] write_kind,
  input  logic [7:0] write_target,
  input  logic [7:0] write_value,
  output int         mismatch_count,
  output int         pending_count
);

  localparam int SLOT_A = 0;
  localparam int SLOT_C = 1;
  localparam int SLOT_G = 2;
  localparam int SLOT_X = 3;
  localparam int SLOT_Y = 4;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] pc;
    logic       halt;
    kind_t      kind;
    logic [7:0] target;
    logic [7:0] value;
  } exec_result_t;

  exec_result_t expected_results[$];

  logic [7:0] gpr [5];
  logic [7:0] data_mem [MEM_DEPTH];
  logic [7:0] pc_shadow;
  logic       halt_shadow;

  function automatic int slot_of(name_t n);
    case (n)
      NAME_A:  return SLOT_A;
      NAME_C:  return SLOT_C;
      NAME_G:  return SLOT_G;
      NAME_X:  return SLOT_X;
      NAME_Y:  return SLOT_Y;
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] read_source(name_t n, logic [7:0] port);
    int s;
    s = slot_of(n);
    if (s >= 0) return gpr[s];
    case (n)
      NAME_B:  return port;
      NAME_D:  return gpr[SLOT_X] - gpr[SLOT_Y];
      NAME_J:  return {7'd0, gpr[SLOT_C] != 8'd0};
      NAME_L:  return gpr[SLOT_A] << L_SHIFT;
      NAME_M:  return data_mem[gpr[SLOT_A]];
      NAME_P:  return pc_shadow;
      NAME_S:  return gpr[SLOT_X] + gpr[SLOT_Y];
      default: return 8'd0;
    endcase
  endfunction

  // Executes one instruction against the shadow state and returns its result beat.
  function automatic exec_result_t execute_instr(logic [2:0] cmd, name_t dst, name_t src,
                                                 logic [7:0] imm, logic [7:0] port);
    exec_result_t r;
    logic         advance;
    logic         c_zero;
    logic [7:0]   v;
    int           s;
    r = '0;
    advance = !halt_shadow;
    c_zero = (gpr[SLOT_C] == 8'd0);
    if (!halt_shadow) begin
      case (cmd)
        CMD_MOV: begin
          v = read_source(src, port);
          if (dst == NAME_M) begin
            data_mem[gpr[SLOT_A]] = v;
            r.kind = KIND_MEM;
            r.target = gpr[SLOT_A];
            r.value = v;
          end else begin
            s = slot_of(dst);
            if (s >= 0) begin
              gpr[s] = v;
              r.kind = KIND_REG;
              r.target = {4'd0, dst};
              r.value = v;
            end
          end
        end
        CMD_LDI: begin
          s = slot_of(dst);
          if (s >= 0) begin
            gpr[s] = imm;
            r.kind = KIND_REG;
            r.target = {4'd0, dst};
            r.value = imm;
          end
        end
        CMD_JEZ: begin
          if (c_zero) begin
            pc_shadow = read_source(src, port);
            advance = 1'b0;
          end
        end
        CMD_JNZ: begin
          if (!c_zero) begin
            pc_shadow = read_source(src, port);
            advance = 1'b0;
          end
        end
        CMD_JNI: begin
          if (!c_zero) begin
            pc_shadow = imm;
            advance = 1'b0;
          end
        end
        CMD_HLT: begin
          halt_shadow = 1'b1;
          advance = 1'b0;
        end
        CMD_RST: begin
          foreach (gpr[i]) gpr[i] = 8'd0;
        end
        default: ;
      endcase
    end
    if (advance) pc_shadow = pc_shadow + 8'd1;
    r.pc = pc_shadow;
    r.halt = halt_shadow;
    return r;
  endfunction

  always @(posedge clk) begin
    exec_result_t got;
    exec_result_t exp;
    if (rst) begin
      foreach (gpr[i]) gpr[i] = 8'd0;
      pc_shadow = 8'd0;
      halt_shadow = 1'b0;
      expected_results.delete();
      mismatch_count = 0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {next_pc, halted_flag, write_kind, write_target, write_value};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: pc=%h halt=%b kind=%0d tgt=%h val=%h",
                     $time, got.pc, got.halt, got.kind, got.target, got.value);
        end else begin
          exp = expected_results.pop_front();
          if (got !== exp) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: mismatch pc %h/%h halt %b/%b kind %0d/%0d tgt %h/%h val %h/%h (exp/got)",
                       $time, exp.pc, got.pc, exp.halt, got.halt, exp.kind, got.kind,
                       exp.target, got.target, exp.value, got.value);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(execute_instr(command, dest_reg, src_reg, immediate, port_b));
      pending_count = expected_results.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Top of the execute block testbench: clock, reset, instruction stimulus and
// output back-pressure. Depends on tac_pkg, the execute block and tac_exec_checker.
`timescale 1ns / 100ps

module tb_top
  import tac_pkg::*;
;

  localparam int         NUM_RANDOM   = 450;
  localparam int         HOLD_CYCLES  = 120;
  localparam int         RUN_LIMIT    = 100000;
  localparam int         DRAIN_CYCLES = 8;
  localparam logic [2:0] CMD_UNDEF    = 3'd7;
  localparam name_t      NAME_SPARE_E = 4'd14;
  localparam name_t      NAME_SPARE_F = 4'd15;

  typedef struct {
    logic [2:0] cmd;
    name_t      dst;
    name_t      src;
    logic [7:0] imm;
    logic [7:0] port;
  } instr_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] command = '0;
  logic [3:0] dest_reg = '0;
  logic [3:0] src_reg = '0;
  logic [7:0] immediate = '0;
  logic [7:0] port_b = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] next_pc;
  logic       halted_flag;
  logic [1:0] write_kind;
  logic [7:0] write_target;
  logic [7:0] write_value;
  int         mismatch_count;
  int         pending_count;

  int         phase = 0;
  logic       hold_req = 1'b0;

  instr_t     program_q[$];

  // What the generator knows about A, so that M is only read once mem[A] holds data.
  logic       a_known;
  logic [7:0] a_val;
  logic       mem_at_a_ok;
  logic       mem_written [MEM_DEPTH];

  always #1 clk = ~clk;

  tiny_accumulator_cpu_execute dut (.*);

  tac_exec_checker u_check (.*);

  function automatic logic m_readable();
    return mem_at_a_ok || (a_known && mem_written[a_val]);
  endfunction

  function automatic void add_instr(logic [2:0] cmd, name_t dst, name_t src,
                                    logic [7:0] imm, logic [7:0] port);
    instr_t it;
    if (src == NAME_M && !m_readable()) src = NAME_S;
    it = '{cmd, dst, src, imm, port};
    program_q.push_back(it);
    case (cmd)
      CMD_MOV: begin
        if (dst == NAME_M) begin
          mem_at_a_ok = 1'b1;
          if (a_known) mem_written[a_val] = 1'b1;
        end else if (dst == NAME_A && src != NAME_A) begin
          a_known = 1'b0;
          mem_at_a_ok = 1'b0;
        end
      end
      CMD_LDI: begin
        if (dst == NAME_A) begin
          a_known = 1'b1;
          a_val = imm;
          mem_at_a_ok = mem_written[imm];
        end
      end
      CMD_RST: begin
        a_known = 1'b1;
        a_val = 8'd0;
        mem_at_a_ok = mem_written[0];
      end
      default: ;
    endcase
  endfunction

  function automatic name_t any_name();
    return name_t'($urandom_range(0, 15));
  endfunction

  function automatic name_t stored_name();
    case ($urandom_range(0, 4))
      0:       return NAME_A;
      1:       return NAME_C;
      2:       return NAME_G;
      3:       return NAME_X;
      default: return NAME_Y;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic void add_random_instr();
    int         pick;
    name_t      d;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      d = ($urandom_range(0, 9) < 7) ? stored_name() : any_name();
      v = rand_byte();
      // Keep A on a few addresses often so that stored bytes get read back later.
      if (d == NAME_A && $urandom_range(0, 1)) v = 8'($urandom_range(0, 7));
      if (d == NAME_C && $urandom_range(0, 1)) v = 8'd0;
      add_instr(CMD_LDI, d, any_name(), v, rand_byte());
    end else if (pick < 46) begin
      d = ($urandom_range(0, 3) != 0) ? stored_name() : any_name();
      add_instr(CMD_MOV, d, any_name(), rand_byte(), rand_byte());
    end else if (pick < 56) begin
      add_instr(CMD_MOV, NAME_M, any_name(), rand_byte(), rand_byte());
    end else if (pick < 68) begin
      if (!m_readable()) add_instr(CMD_MOV, NAME_M, any_name(), rand_byte(), rand_byte());
      if ($urandom_range(0, 3) == 0)
        add_instr($urandom_range(0, 1) ? CMD_JEZ : CMD_JNZ, any_name(), NAME_M,
                  rand_byte(), rand_byte());
      else
        add_instr(CMD_MOV, stored_name(), NAME_M, rand_byte(), rand_byte());
    end else if (pick < 84) begin
      case ($urandom_range(0, 2))
        0:       add_instr(CMD_JEZ, any_name(), any_name(), rand_byte(), rand_byte());
        1:       add_instr(CMD_JNZ, any_name(), any_name(), rand_byte(), rand_byte());
        default: add_instr(CMD_JNI, any_name(), any_name(), rand_byte(), rand_byte());
      endcase
    end else if (pick < 90) begin
      add_instr(CMD_RST, any_name(), any_name(), rand_byte(), rand_byte());
    end else if (pick < 94) begin
      add_instr(CMD_UNDEF, any_name(), any_name(), rand_byte(), rand_byte());
    end else begin
      add_instr(CMD_MOV, NAME_A, any_name(), rand_byte(), rand_byte());
    end
  endfunction

  function automatic void build_program();
    int directed_count;
    foreach (mem_written[i]) mem_written[i] = 1'b0;
    a_known = 1'b1;
    a_val = 8'd0;
    mem_at_a_ok = 1'b0;

    // Field extremes and every derived source.
    add_instr(CMD_LDI, NAME_A, NAME_A, 8'hFF, 8'h00);
    add_instr(CMD_LDI, NAME_X, NAME_B, 8'h80, 8'hFF);
    add_instr(CMD_LDI, NAME_Y, NAME_C, 8'h81, 8'h00);
    add_instr(CMD_MOV, NAME_M, NAME_X, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_C, NAME_M, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_G, NAME_D, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_G, NAME_S, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_X, NAME_L, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_Y, NAME_J, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_G, NAME_P, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_A, NAME_B, 8'h00, 8'hFF);
    add_instr(CMD_MOV, NAME_X, NAME_SPARE_E, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_G, NAME_SPARE_F, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_C, NAME_N, 8'h00, 8'h00);
    // Destinations that are not stored write nothing; ldi to M writes nothing either.
    add_instr(CMD_LDI, NAME_B, NAME_Z, 8'h55, 8'h00);
    add_instr(CMD_LDI, NAME_M, NAME_Z, 8'hAA, 8'h00);
    add_instr(CMD_MOV, NAME_P, NAME_Y, 8'h00, 8'h00);
    add_instr(CMD_MOV, NAME_SPARE_F, NAME_Z, 8'h00, 8'h00);
    // Jumps with C zero, then with C set; the last jump lets the pc wrap to zero.
    add_instr(CMD_JEZ, NAME_A, NAME_Y, 8'h00, 8'h00);
    add_instr(CMD_JNZ, NAME_A, NAME_X, 8'h00, 8'h00);
    add_instr(CMD_JNI, NAME_A, NAME_A, 8'h10, 8'h00);
    add_instr(CMD_LDI, NAME_C, NAME_A, 8'h01, 8'h00);
    add_instr(CMD_JNZ, NAME_A, NAME_B, 8'h00, 8'hFE);
    add_instr(CMD_JEZ, NAME_A, NAME_B, 8'h00, 8'h00);
    add_instr(CMD_JNI, NAME_A, NAME_A, 8'hFF, 8'h00);
    add_instr(CMD_UNDEF, NAME_A, NAME_A, 8'h00, 8'h00);
    add_instr(CMD_RST, NAME_A, NAME_A, 8'h00, 8'h00);

    directed_count = program_q.size();
    while (program_q.size() < directed_count + NUM_RANDOM) add_random_instr();

    // Halt is final: everything after it must be ignored.
    add_instr(CMD_HLT, any_name(), any_name(), rand_byte(), rand_byte());
    add_instr(CMD_LDI, NAME_A, NAME_A, rand_byte(), rand_byte());
    add_instr(CMD_MOV, NAME_X, NAME_B, rand_byte(), rand_byte());
    add_instr(CMD_JNI, NAME_A, NAME_A, rand_byte(), rand_byte());
    add_instr(CMD_RST, NAME_A, NAME_A, rand_byte(), rand_byte());
    add_instr(CMD_HLT, NAME_A, NAME_A, rand_byte(), rand_byte());
  endfunction

  // Sender: offers every instruction beat in order; in each cycle it may idle
  // with the probability of the current phase.
  initial begin
    instr_t it;
    int     n;
    int     idle_pct;
    int     p;
    build_program();
    n = program_q.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < n; i++) begin
      it = program_q[i];
      p = (i < n / 3) ? 0 : (i < 2 * n / 3) ? 1 : 2;
      phase <= p;
      if (i == 5 * n / 6) hold_req <= 1'b1;
      idle_pct = (p == 0) ? 29 : (p == 1) ? 76 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid  <= 1'b1;
      command   <= it.cmd;
      dest_reg  <= it.dst;
      src_reg   <= it.src;
      immediate <= it.imm;
      port_b    <= it.port;
      @(posedge clk);
      while (in_stall !== 1'b0) @(posedge clk);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls per phase, plus one long hold-off so the block backs up.
  initial begin
    int   pct;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        pct = (phase == 0) ? 76 : (phase == 1) ? 29 : 0;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
